// ----- src/utf8_char_normalizer_core_assert.svh -----
// ----------------------------------------------------------------------------
// utf8 normalizer assertion macros
// concurrent check helpers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef UTF8_CHAR_NORMALIZER_CORE_ASSERT_SVH
`define UTF8_CHAR_NORMALIZER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define UCN_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ucn check failed");
`define UCN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ucn check failed");
`else
`define UCN_ASSERT_IMPL(label, ante, cons)
`define UCN_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- src/ucn_pkg.sv -----
// ----------------------------------------------------------------------------
// ucn_pkg
// shared types, constants and the code point normalizer function
// ----------------------------------------------------------------------------
`default_nettype none
package ucn_pkg;

  localparam logic [20:0] REPL_CP    = 21'h00FFFD;
  localparam logic [20:0] MAX_CP     = 21'h10FFFF;
  localparam logic [20:0] SURR_LO    = 21'h00D800;
  localparam logic [20:0] SURR_HI    = 21'h00DFFF;
  localparam logic [20:0] FW_LO      = 21'h00FF01;
  localparam logic [20:0] FW_HI      = 21'h00FF5E;
  localparam logic [20:0] FW_SHIFT   = 21'h00FEE0;
  localparam logic [20:0] IDEO_SPACE = 21'h003000;

  typedef struct packed {
    logic [20:0] cp;
    logic        last;
  } q_entry_t;

  typedef struct packed {
    logic       busy;
    logic [2:0] count;
  } front_stat_t;

  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      len;
  } norm_t;

  function automatic norm_t utf8_encode(input logic [20:0] cp);
    norm_t r;
    r = '0;
    if (cp < 21'h80) begin
      r.b[0] = cp[7:0];
      r.len  = 3'd1;
    end else if (cp < 21'h800) begin
      r.b[0] = {3'b110, cp[10:6]};
      r.b[1] = {2'b10, cp[5:0]};
      r.len  = 3'd2;
    end else if (cp < 21'h10000) begin
      r.b[0] = {4'b1110, cp[15:12]};
      r.b[1] = {2'b10, cp[11:6]};
      r.b[2] = {2'b10, cp[5:0]};
      r.len  = 3'd3;
    end else begin
      r.b[0] = {5'b11110, cp[20:18]};
      r.b[1] = {2'b10, cp[17:12]};
      r.b[2] = {2'b10, cp[11:6]};
      r.b[3] = {2'b10, cp[5:0]};
      r.len  = 3'd4;
    end
    return r;
  endfunction

  function automatic norm_t normalize(input logic [20:0] cp);
    norm_t       r;
    logic [20:0] t;
    r = '0;
    t = cp - FW_SHIFT;
    if (cp >= FW_LO && cp <= FW_HI) begin
      r.b[0] = t[7:0];
      r.len  = 3'd1;
    end else if (cp == IDEO_SPACE) begin
      r.b[0] = 8'h20;
      r.len  = 3'd1;
    end else begin
      case (cp) inside
        [21'h2018:21'h201B]: begin r.b[0] = 8'h27; r.len = 3'd1; end
        [21'h201C:21'h201F]: begin r.b[0] = 8'h22; r.len = 3'd1; end
        21'hFB00: begin r.b[0] = "f"; r.b[1] = "f"; r.len = 3'd2; end
        21'hFB01: begin r.b[0] = "f"; r.b[1] = "i"; r.len = 3'd2; end
        21'hFB02: begin r.b[0] = "f"; r.b[1] = "l"; r.len = 3'd2; end
        21'hFB03: begin r.b[0] = "f"; r.b[1] = "f"; r.b[2] = "i"; r.len = 3'd3; end
        21'hFB04: begin r.b[0] = "f"; r.b[1] = "f"; r.b[2] = "l"; r.len = 3'd3; end
        21'hFB05, 21'hFB06: begin r.b[0] = "s"; r.b[1] = "t"; r.len = 3'd2; end
        default: r = utf8_encode(cp);
      endcase
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- src/utf8_char_normalizer_core.sv -----
// ----------------------------------------------------------------------------
// utf8_char_normalizer_core
// streaming utf-8 decode, character normalization and re-encode
// ----------------------------------------------------------------------------
// path: accepted byte -> window, decoded code point -> queue -> output stage
// input: full stays high after each accepted byte until the decoder has queued
//   each code point it can complete; a full queue stalls the decoder
// output: one byte per cycle while popped, so bytes-per-character sets the rate
// reset: synchronous active-low rst_n empties window, queue and output stage
`default_nettype none
`include "utf8_char_normalizer_core_assert.svh"
module utf8_char_normalizer_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_text_end,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte,
  output logic            out_last
);
  import ucn_pkg::*;

  // decoder to encoder queue
  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_empty;
  q_entry_t    q_wdata;
  q_entry_t    q_rdata;
  front_stat_t fstat;

  // front: window of held bytes plus the new one, decoded head first
  ucn_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .in_byte     (in_byte),
    .in_text_end (in_text_end),
    .full        (full),
    .q_push      (q_push),
    .q_data      (q_wdata),
    .q_full      (q_full),
    .stat        (fstat)
  );

  // short queue decouples the two sides
  ucn_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_push),
    .wdata   (q_wdata),
    .q_full  (q_full),
    .rd      (q_pop),
    .rdata   (q_rdata),
    .q_empty (q_empty)
  );

  // back: map the code point and emit its bytes
  ucn_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_data   (q_rdata),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .out_last (out_last)
  );

  // queue is never written when full
  `UCN_ASSERT_IMPL(a_q_no_overflow, q_push, !q_full)
  // an idle decoder holds at most three bytes
  `UCN_ASSERT_IMPL(a_idle_pending, !fstat.busy, fstat.count <= 3'd3)
  // last marker only on a shown item
  `UCN_ASSERT_IMPL(a_last_shown, empty, !out_last)
  // an accepted item always makes the decoder busy (full) after the edge that takes it
  `UCN_ASSERT_NEXT(a_busy_after_accept, push && !full, full)

endmodule
`default_nettype wire

// ----- src/ucn_front.sv -----
// ----------------------------------------------------------------------------
// ucn_front
// window and utf-8 decoder, one code point per cycle while the queue has room
// ----------------------------------------------------------------------------
`default_nettype none
module ucn_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire logic [7:0]         in_byte,
  input  wire logic               in_text_end,
  output logic                    full,
  output logic                    q_push,
  output ucn_pkg::q_entry_t       q_data,
  input  wire logic               q_full,
  output ucn_pkg::front_stat_t    stat
);
  import ucn_pkg::*;

  logic [3:0][7:0] w_r, w_nxt;
  logic [2:0]      n_r, n_nxt;
  logic            end_r, end_nxt;
  logic            busy_r, busy_nxt;

  logic [7:0]  lead;
  logic [2:0]  len;
  logic [2:0]  cons;
  logic [20:0] cp;
  logic [20:0] asm;
  logic [20:0] min_cp;
  logic        ok;
  logic        brk;

  // decode at the window head
  always_comb begin
    lead = w_r[0];
    if (!lead[7])                 len = 3'd1;
    else if (lead[7:5] == 3'b110)   len = 3'd2;
    else if (lead[7:4] == 4'b1110)  len = 3'd3;
    else if (lead[7:3] == 5'b11110) len = 3'd4;
    else                            len = 3'd0;
    ok = 1'b1;
    for (int i = 1; i < 4; i++) begin
      if (3'(i) < len && 3'(i) < n_r && w_r[i][7:6] != 2'b10) ok = 1'b0;
    end
    case (len)
      3'd2:    begin asm = {10'd0, lead[4:0], w_r[1][5:0]};                  min_cp = 21'h80;    end
      3'd3:    begin asm = {5'd0, lead[3:0], w_r[1][5:0], w_r[2][5:0]};     min_cp = 21'h800;   end
      default: begin asm = {lead[2:0], w_r[1][5:0], w_r[2][5:0], w_r[3][5:0]}; min_cp = 21'h10000; end
    endcase
    brk  = 1'b0;
    cons = 3'd1;
    cp   = REPL_CP;
    if (len == 3'd1) begin
      cp = {13'd0, lead};
    end else if (len != 3'd0 && ok) begin
      if (n_r < len) begin
        brk = !end_r;
      end else if (asm >= min_cp && asm <= MAX_CP && !(asm >= SURR_LO && asm <= SURR_HI)) begin
        cp   = asm;
        cons = len;
      end
    end
  end

  always_comb begin
    w_nxt    = w_r;
    n_nxt    = n_r;
    end_nxt  = end_r;
    busy_nxt = busy_r;
    q_push   = 1'b0;
    if (!busy_r) begin
      if (push) begin
        w_nxt[n_r[1:0]] = in_byte;
        n_nxt    = n_r + 3'd1;
        end_nxt  = in_text_end;
        busy_nxt = 1'b1;
      end
    end else if (brk) begin
      busy_nxt = 1'b0;
    end else if (!q_full) begin
      q_push = 1'b1;
      for (int i = 0; i < 4; i++) begin
        if (i + int'(cons) < 4) w_nxt[i] = w_r[2'(i + int'(cons))];
      end
      n_nxt = n_r - cons;
      if (n_nxt == 3'd0) busy_nxt = 1'b0;
    end
  end

  assign q_data.cp   = cp;
  assign q_data.last = end_r && (n_r == cons);
  assign full        = busy_r;
  assign stat.busy   = busy_r;
  assign stat.count  = n_r;

  always_ff @(posedge clk) begin
    w_r <= w_nxt;
    end_r <= end_nxt;
    if (!rst_n) begin
      n_r    <= 3'd0;
      busy_r <= 1'b0;
    end else begin
      n_r    <= n_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- src/ucn_fifo.sv -----
// ----------------------------------------------------------------------------
// ucn_fifo
// two-entry code point queue between decoder and encoder
// ----------------------------------------------------------------------------
`default_nettype none
module ucn_fifo (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               wr,
  input  wire ucn_pkg::q_entry_t  wdata,
  output logic                    q_full,
  input  wire logic               rd,
  output ucn_pkg::q_entry_t       rdata,
  output logic                    q_empty
);
  import ucn_pkg::*;

  q_entry_t   mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign q_full  = (cnt_r == 2'd2);
  assign q_empty = (cnt_r == 2'd0);
  assign rdata   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wdata;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule
`default_nettype wire

// ----- src/ucn_back.sv -----
// ----------------------------------------------------------------------------
// ucn_back
// normalizes a code point; its utf-8 bytes leave one per cycle while popped
// ----------------------------------------------------------------------------
`default_nettype none
module ucn_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ucn_pkg::q_entry_t  q_data,
  input  wire logic               q_empty,
  output logic                    q_pop,
  output logic                    empty,
  input  wire logic               pop,
  output logic [7:0]              out_byte,
  output logic                    out_last
);
  import ucn_pkg::*;

  logic [3:0][7:0] seq_r;
  logic [2:0]      cnt_r;
  logic            last_r;
  logic            take;
  norm_t           nm;

  assign empty    = (cnt_r == 3'd0);
  assign take     = pop && !empty;
  assign q_pop    = !q_empty && (empty || (cnt_r == 3'd1 && take));
  assign nm       = normalize(q_data.cp);
  assign out_byte = seq_r[0];
  assign out_last = last_r && (cnt_r == 3'd1);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      seq_r  <= nm.b;
      last_r <= q_data.last;
    end else if (take) begin
      seq_r <= {8'h00, seq_r[3:1]};
    end
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else if (q_pop) begin
      cnt_r <= nm.len;
    end else if (take) begin
      cnt_r <= cnt_r - 3'd1;
    end
  end

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// utf8_char_normalizer_core testbench
// drives raw utf-8 byte streams through the normalizer, predicts the output
// bytes with an independent decode/normalize/encode model and checks each one
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [7:0] data;
    logic       text_end;
  } in_item_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } out_item_t;

  logic       clk;
  logic       rst_n;
  logic       push;
  logic       full;
  logic [7:0] in_byte;
  logic       in_text_end;
  logic       empty;
  logic       pop;
  logic [7:0] out_byte;
  logic       out_last;

  utf8_char_normalizer_core dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_byte(in_byte),
    .in_text_end(in_text_end), .empty(empty), .pop(pop), .out_byte(out_byte),
    .out_last(out_last)
  );

  // pending stimulus and expected output bytes
  in_item_t  byte_queue[$];
  out_item_t expected_bytes[$];

  // predictor copy of the decoder window
  logic [7:0] held_bytes[3];
  int         held_count;

  int  errors;
  int  idle_cycles;
  int  in_gap;
  int  out_gap;
  int  hold_off;
  bit  stim_done;
  bit  hold_armed;

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // ---------------------------------------------------------------- predictor
  function automatic int seq_length(input logic [7:0] b);
    if (b[7] == 1'b0) return 1;
    if (b[7:5] == 3'b110) return 2;
    if (b[7:4] == 4'b1110) return 3;
    if (b[7:3] == 5'b11110) return 4;
    return 0;
  endfunction

  task automatic emit(input logic [7:0] b);
    out_item_t o;
    o.data = b;
    o.last = 1'b0;
    expected_bytes = {expected_bytes, o};
  endtask

  task automatic emit_utf8(input logic [20:0] cp);
    if (cp < 21'h80) begin
      emit(cp[7:0]);
    end else if (cp < 21'h800) begin
      emit({3'b110, cp[10:6]});
      emit({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      emit({4'b1110, cp[15:12]});
      emit({2'b10, cp[11:6]});
      emit({2'b10, cp[5:0]});
    end else begin
      emit({5'b11110, cp[20:18]});
      emit({2'b10, cp[17:12]});
      emit({2'b10, cp[11:6]});
      emit({2'b10, cp[5:0]});
    end
  endtask

  // fold fullwidth forms, ideographic space, curly quotes and ligatures
  task automatic emit_normalized(input logic [20:0] cp);
    logic [20:0] t;
    t = cp - ucn_pkg::FW_SHIFT;
    if (cp >= ucn_pkg::FW_LO && cp <= ucn_pkg::FW_HI) emit(t[7:0]);
    else if (cp == ucn_pkg::IDEO_SPACE) emit(8'h20);
    else if (cp >= 21'h2018 && cp <= 21'h201B) emit(8'h27);
    else if (cp >= 21'h201C && cp <= 21'h201F) emit(8'h22);
    else if (cp == 21'hFB00) begin emit("f"); emit("f"); end
    else if (cp == 21'hFB01) begin emit("f"); emit("i"); end
    else if (cp == 21'hFB02) begin emit("f"); emit("l"); end
    else if (cp == 21'hFB03) begin emit("f"); emit("f"); emit("i"); end
    else if (cp == 21'hFB04) begin emit("f"); emit("f"); emit("l"); end
    else if (cp == 21'hFB05 || cp == 21'hFB06) begin emit("s"); emit("t"); end
    else emit_utf8(cp);
  endtask

  task automatic predict_byte(input in_item_t it);
    logic [7:0]  win[4];
    logic [20:0] cp;
    logic [20:0] floor_cp;
    int n, pos, len, avail, upto, base_count;
    bit ok, stop;
    base_count = expected_bytes.size();
    for (int i = 0; i < held_count; i++) win[i] = held_bytes[i];
    n = held_count + 1;
    win[held_count] = it.data;
    pos = 0;
    stop = 0;
    while (pos < n && !stop) begin
      len = seq_length(win[pos]);
      avail = n - pos;
      if (len == 1) begin
        emit_normalized({13'd0, win[pos]});
        pos++;
      end else if (len == 0) begin
        emit_normalized(ucn_pkg::REPL_CP);
        pos++;
      end else begin
        upto = (avail < len) ? avail : len;
        ok = 1;
        for (int i = 1; i < upto; i++)
          if (win[pos+i][7:6] != 2'b10) ok = 0;
        if (!ok) begin
          emit_normalized(ucn_pkg::REPL_CP);
          pos++;
        end else if (avail < len) begin
          if (!it.text_end) stop = 1;
          else begin
            emit_normalized(ucn_pkg::REPL_CP);
            pos++;
          end
        end else begin
          // assemble and reject overlong, surrogate and out of range forms
          case (len)
            2: begin cp = {16'd0, win[pos][4:0]}; floor_cp = 21'h80; end
            3: begin cp = {17'd0, win[pos][3:0]}; floor_cp = 21'h800; end
            default: begin cp = {18'd0, win[pos][2:0]}; floor_cp = 21'h10000; end
          endcase
          for (int i = 1; i < len; i++) cp = {cp[14:0], win[pos+i][5:0]};
          if (cp >= floor_cp && cp <= ucn_pkg::MAX_CP &&
              !(cp >= ucn_pkg::SURR_LO && cp <= ucn_pkg::SURR_HI)) begin
            emit_normalized(cp);
            pos += len;
          end else begin
            emit_normalized(ucn_pkg::REPL_CP);
            pos++;
          end
        end
      end
    end
    held_count = n - pos;
    for (int i = 0; i < held_count; i++) held_bytes[i] = win[pos+i];
    if (it.text_end && expected_bytes.size() > base_count)
      expected_bytes[expected_bytes.size()-1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------- stimulus
  task automatic add_byte(input logic [7:0] b, input logic e);
    in_item_t it;
    it.data = b;
    it.text_end = e;
    byte_queue = {byte_queue, it};
  endtask

  task automatic add_cp(input logic [20:0] cp);
    if (cp < 21'h80) add_byte(cp[7:0], 1'b0);
    else if (cp < 21'h800) begin
      add_byte({3'b110, cp[10:6]}, 1'b0); add_byte({2'b10, cp[5:0]}, 1'b0);
    end else if (cp < 21'h10000) begin
      add_byte({4'b1110, cp[15:12]}, 1'b0); add_byte({2'b10, cp[11:6]}, 1'b0);
      add_byte({2'b10, cp[5:0]}, 1'b0);
    end else begin
      add_byte({5'b11110, cp[20:18]}, 1'b0); add_byte({2'b10, cp[17:12]}, 1'b0);
      add_byte({2'b10, cp[11:6]}, 1'b0); add_byte({2'b10, cp[5:0]}, 1'b0);
    end
  endtask

  function automatic logic [20:0] random_cp();
    case ($urandom_range(0, 9))
      0, 1: return 21'($urandom_range(0, 21'h7F));
      2: return 21'($urandom_range(21'hFF01, 21'hFF5E));
      3: return ucn_pkg::IDEO_SPACE;
      4: return 21'($urandom_range(21'h2018, 21'h201F));
      5: return 21'($urandom_range(21'hFB00, 21'hFB06));
      6: return 21'($urandom_range(21'h80, 21'h7FF));
      7: return 21'($urandom_range(21'h800, 21'hD7FF));
      8: return 21'($urandom_range(21'hE000, 21'hFFFF));
      default: return 21'($urandom_range(21'h10000, 21'h10FFFF));
    endcase
  endfunction

  initial begin
    int total;
    push = 1'b0; pop = 1'b0; in_byte = 8'h00; in_text_end = 1'b0;
    rst_n = 1'b0;
    errors = 0; held_count = 0; stim_done = 0; hold_armed = 0;

    // directed: ascii extremes, folds, invalid leads, broken sequences
    add_byte(8'h00, 1'b0); add_byte(8'h7F, 1'b0);
    add_cp(21'hFF01); add_cp(21'hFF5E); add_cp(ucn_pkg::IDEO_SPACE);
    add_cp(21'h201D); add_cp(21'hFB03); add_cp(21'h10FFFF);
    add_byte(8'h80, 1'b0); add_byte(8'hFF, 1'b0);          // invalid leads
    add_byte(8'hE2, 1'b0); add_byte(8'h41, 1'b0);          // bad continuation
    add_byte(8'hC0, 1'b0); add_byte(8'hAF, 1'b0);          // overlong
    add_byte(8'hED, 1'b0); add_byte(8'hA0, 1'b0); add_byte(8'h80, 1'b0); // surrogate
    add_byte(8'hF4, 1'b0); add_byte(8'h90, 1'b0); add_byte(8'h80, 1'b0);
    add_byte(8'h80, 1'b0);                                 // above max
    add_byte(8'hF0, 1'b0); add_byte(8'h9F, 1'b0); add_byte(8'h98, 1'b1); // truncated

    // random texts: mostly valid code points, some raw noise bytes
    total = byte_queue.size();
    while (total < 525) begin
      int chars;
      chars = $urandom_range(1, 12);
      for (int c = 0; c < chars; c++) begin
        if ($urandom_range(0, 9) == 0) add_byte(8'($urandom), 1'b0);
        else add_cp(random_cp());
      end
      // end some texts mid-sequence to hit truncation
      if ($urandom_range(0, 3) == 0) add_byte(8'($urandom_range(8'hC0, 8'hF7)), 1'b1);
      else byte_queue[byte_queue.size()-1].text_end = 1'b1;
      total = byte_queue.size();
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    hold_armed = 1;
  end

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin
    if (rst_n) begin
      // item taken at this edge: feed predictor
      if (push && !full) begin
        in_item_t it;
        it.data = in_byte;
        it.text_end = in_text_end;
        predict_byte(it);
        void'(byte_queue.pop_front());
      end
      if (!(push && full)) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          push <= 1'b0;
        end else if (byte_queue.size() > 0 && !(push && !full && byte_queue.size() == 0)) begin
          push <= 1'b1;
          in_byte <= byte_queue[0].data;
          in_text_end <= byte_queue[0].text_end;
          // random gap before the next item: mostly none, sometimes long
          case ($urandom_range(0, 15))
            0, 1, 2: in_gap <= $urandom_range(1, 3);
            3: in_gap <= $urandom_range(10, 40);
            default: in_gap <= 0;
          endcase
        end else begin
          push <= 1'b0;
          if (byte_queue.size() == 0) stim_done <= 1'b1;
        end
      end
    end else begin
      in_gap <= 0;
      push <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- monitor
  task automatic report(input string what, input logic [7:0] got_b, input logic got_l,
                        input logic [7:0] exp_b, input logic exp_l);
    $display("mismatch %s: got byte %h last %b, expected byte %h last %b",
             what, got_b, got_l, exp_b, exp_l);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (pop && !empty) begin
        if (expected_bytes.size() == 0) report("unexpected", out_byte, out_last, 8'h00, 1'b0);
        else begin
          out_item_t e;
          e = expected_bytes.pop_front();
          if (out_byte !== e.data || out_last !== e.last)
            report("field", out_byte, out_last, e.data, e.last);
        end
      end
      // long hold-off once, while the sender keeps offering items
      if (hold_armed && byte_queue.size() < 400 && hold_off == 0 && out_gap >= 0) begin
        hold_armed <= 0;
        hold_off <= 300;
        pop <= 1'b0;
      end else if (hold_off > 1) begin
        hold_off <= hold_off - 1;
        pop <= 1'b0;
      end else if (out_gap > 0) begin
        hold_off <= 0;
        out_gap <= out_gap - 1;
        pop <= 1'b0;
      end else begin
        hold_off <= 0;
        pop <= 1'b1;
        case ($urandom_range(0, 15))
          0, 1, 2: out_gap <= $urandom_range(1, 3);
          3: out_gap <= $urandom_range(10, 40);
          default: out_gap <= 0;
        endcase
      end
    end else begin
      pop <= 1'b0;
      out_gap <= 0;
      hold_off <= 0;
    end
  end

  // ---------------------------------------------------------------- watchdog and end
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    idle_cycles = 0;
    in_gap = 0; out_gap = 0; hold_off = 0;
    @(posedge rst_n);
    while (!(stim_done && expected_bytes.size() == 0) && idle_cycles < WATCHDOG_LIMIT)
      @(posedge clk);
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** utf8_char_normalizer_core: FAILED **");
    end else begin
      // allow a stray extra byte to surface
      repeat (20) @(posedge clk);
      if (errors == 0 && expected_bytes.size() == 0)
        $display("** utf8_char_normalizer_core: PASSED **");
      else
        $display("** utf8_char_normalizer_core: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- filelist.f -----
+incdir+src
src/ucn_pkg.sv
src/ucn_front.sv
src/ucn_fifo.sv
src/ucn_back.sv
src/utf8_char_normalizer_core.sv
test/testbench.sv
